@@ src/lpg_pkg.sv @@
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared constants, types and the colour wheel for the LED pattern generator.
// ----------------------------------------------------------------------------
package lpg_pkg;

  localparam int unsigned LED_COUNT          = 128;
  localparam int unsigned FRAMES_PER_PATTERN = 626;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned CHANS    = 3;
  localparam int unsigned TICKS_W  = 10;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [2:0] MODE_PINWHEEL    = 3'd0;
  localparam logic [2:0] MODE_HORIZONTAL  = 3'd1;
  localparam logic [2:0] MODE_SPIRAL      = 3'd2;
  localparam logic [2:0] MODE_VERTICAL    = 3'd3;
  localparam logic [2:0] MODE_FRAMEBUFFER = 3'd4;
  localparam logic [2:0] MODE_CYCLE       = 3'd5;
  localparam logic [2:0] MODE_RELEASE     = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS   = 1'b1;

  localparam logic [2:0] PATTERN_MODE_RST = MODE_CYCLE;
  localparam logic [7:0] BRIGHTNESS_RST   = 8'd12;
  localparam logic [1:0] PATTERN_SLOT_RST = 2'd1;

  localparam logic [7:0] WHEEL_SEG1 = 8'd85;
  localparam logic [7:0] WHEEL_SEG2 = 8'd170;
  localparam logic [7:0] CHAN_MAX   = 8'd255;

  localparam logic [7:0] SPIRAL_TOP = 8'(LED_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } lpg_state_e;

  typedef struct packed {
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] blue;
  } lpg_rgb_t;

  typedef struct packed {
    logic start;
  } lpg_div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lpg_div_stat_t;

  function automatic lpg_rgb_t wheel(input logic [7:0] hue);
    logic [7:0] p;
    logic [7:0] q;
    logic [9:0] q3w;
    logic [7:0] q3;
    lpg_rgb_t   c;
    p = 8'd0 - hue;
    if (p < WHEEL_SEG1) begin
      q = p;
    end else if (p < WHEEL_SEG2) begin
      q = p - WHEEL_SEG1;
    end else begin
      q = p - WHEEL_SEG2;
    end
    q3w = {1'b0, q, 1'b0} + {2'b00, q};
    q3  = q3w[7:0];
    if (p < WHEEL_SEG1) begin
      c.green = '0;
      c.red   = CHAN_MAX - q3;
      c.blue  = q3;
    end else if (p < WHEEL_SEG2) begin
      c.green = q3;
      c.red   = '0;
      c.blue  = CHAN_MAX - q3;
    end else begin
      c.green = CHAN_MAX - q3;
      c.red   = q3;
      c.blue  = '0;
    end
    return c;
  endfunction

endpackage

@@ src/lpg_in_if.sv @@
// ----------------------------------------------------------------------------
// lpg_in_if
// LED request channel: valid/ready handshake with per-LED payload.
// ----------------------------------------------------------------------------
interface lpg_in_if;
  logic       valid;
  logic       ready;
  logic [6:0] led_index;
  logic [7:0] x_coord;
  logic [7:0] y_coord;
  logic [6:0] order_position;
  logic [7:0] pixel_byte;
  logic       frame_end;

  modport source (
    output valid, led_index, x_coord, y_coord, order_position, pixel_byte, frame_end,
    input  ready
  );

  modport sink (
    input  valid, led_index, x_coord, y_coord, order_position, pixel_byte, frame_end,
    output ready
  );
endinterface

@@ src/lpg_out_if.sv @@
// ----------------------------------------------------------------------------
// lpg_out_if
// Pixel result channel: valid/ready handshake with colour bytes.
// ----------------------------------------------------------------------------
interface lpg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] green;
  logic [7:0] red;
  logic [7:0] blue;
  logic       drive_enable;

  modport source (
    output valid, green, red, blue, drive_enable,
    input  ready
  );

  modport sink (
    input  valid, green, red, blue, drive_enable,
    output ready
  );
endinterface

@@ src/lpg_divider.sv @@
// ----------------------------------------------------------------------------
// lpg_divider
// Restoring divider, one quotient bit per cycle, shared by the three
// channels in turn (green, red, blue).
// ----------------------------------------------------------------------------
module lpg_divider (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lpg_pkg::lpg_div_ctrl_t ctrl_i,
  input  lpg_pkg::lpg_rgb_t      chan_i,
  input  logic [7:0]             divisor_i,
  output lpg_pkg::lpg_div_stat_t stat_o,
  output lpg_pkg::lpg_rgb_t      quot_o
);
  import lpg_pkg::*;

  localparam int unsigned STEPS  = CHAN_W * CHANS;
  localparam int unsigned STEP_W = $clog2(STEPS);

  logic                    active_q, active_d;
  logic                    done_q, done_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [CHAN_W-1:0]       rem_q, rem_d;
  logic [CHAN_W-1:0]       dsr_q, dsr_d;
  logic [STEPS-1:0]        sh_q, sh_d;
  logic [CHAN_W:0]         trial;
  logic [CHAN_W:0]         diff;
  logic                    ge;
  logic                    last_step;
  logic                    chan_last;

  assign trial     = {rem_q, sh_q[STEPS-1]};
  assign ge        = trial >= {1'b0, dsr_q};
  assign diff      = trial - {1'b0, dsr_q};
  assign last_step = step_q == STEP_W'(STEPS - 1);
  assign chan_last = step_q[$clog2(CHAN_W)-1:0] == '1;

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    step_d   = step_q;
    rem_d    = rem_q;
    dsr_d    = dsr_q;
    sh_d     = sh_q;
    if (ctrl_i.start) begin
      active_d = 1'b1;
      step_d   = '0;
      rem_d    = '0;
      dsr_d    = (divisor_i == '0) ? CHAN_W'(1) : divisor_i;
      sh_d     = chan_i;
    end else if (active_q) begin
      sh_d   = {sh_q[STEPS-2:0], ge};
      rem_d  = chan_last ? '0 : (ge ? diff[CHAN_W-1:0] : trial[CHAN_W-1:0]);
      step_d = step_q + STEP_W'(1);
      if (last_step) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      step_q   <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      step_q   <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    sh_q  <= sh_d;
  end

  assign stat_o.busy = active_q;
  assign stat_o.done = done_q;
  assign quot_o      = sh_q;

endmodule

@@ src/led_pattern_pixel_generator.sv @@
// ----------------------------------------------------------------------------
// led_pattern_pixel_generator
// Rainbow / framebuffer pixel colour generator with brightness division.
// ----------------------------------------------------------------------------
//  channel  dir  handshake        payload
//  in_if    in   valid/ready      led_index x_coord y_coord order_position
//                                 pixel_byte frame_end
//  out_if   out  valid/ready      green red blue drive_enable
//  cfg      in   cfg_we_i         cfg_index_i cfg_data_i (write only)
//
//  Each item passes through: accept, 24 divider steps (8 per channel on
//  the shared restoring divider), then the load of the output register.
//  in_if.ready is high only while idle; a pending result does not block
//  acceptance, only the final load waits for the output register to free.
//  Reset: mode cycle, divisor 12, frame counter 0, pattern slot 1.
// ----------------------------------------------------------------------------
module led_pattern_pixel_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  lpg_in_if.sink                         in_if,
  lpg_out_if.source                      out_if,
  input  logic                           cfg_we_i,
  input  logic [lpg_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lpg_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import lpg_pkg::*;

  lpg_state_e          state_q, state_d;
  logic [2:0]          mode_q;
  logic [7:0]          bright_q;
  logic [7:0]          frame_count_q;
  logic [TICKS_W-1:0]  frame_ticks_q;
  logic [1:0]          slot_q;
  logic                drive_pend_q;

  logic                out_valid_q, out_valid_d;
  lpg_rgb_t            out_rgb_q;
  logic                out_drive_q;

  logic                accept;
  logic                release_mode;
  logic [2:0]          pat;
  logic [7:0]          spiral_sub;
  logic [7:0]          base;
  logic [7:0]          hue;
  lpg_rgb_t            chan;
  logic [TICKS_W-1:0]  ticks_inc;
  logic                load_out;

  lpg_div_ctrl_t       div_ctrl;
  lpg_div_stat_t       div_stat;
  lpg_rgb_t            quot;

  assign accept       = in_if.valid && in_if.ready;
  assign release_mode = mode_q >= MODE_RELEASE;
  assign pat          = (mode_q == MODE_CYCLE) ? {1'b0, slot_q} : mode_q;
  assign spiral_sub   = SPIRAL_TOP - {1'b0, in_if.order_position};
  assign hue          = base + frame_count_q;

  always_comb begin
    case (pat)
      MODE_PINWHEEL:   base = {in_if.led_index, 1'b0};
      MODE_HORIZONTAL: base = in_if.x_coord;
      MODE_SPIRAL:     base = {spiral_sub[6:0], 1'b0};
      MODE_VERTICAL:   base = in_if.y_coord;
      default:         base = '0;
    endcase
  end

  always_comb begin
    if (release_mode) begin
      chan = '0;
    end else if (pat == MODE_FRAMEBUFFER) begin
      chan.green = {in_if.pixel_byte[4:2], 5'b0};
      chan.red   = {in_if.pixel_byte[7:5], 5'b0};
      chan.blue  = {1'b0, in_if.pixel_byte[1:0], 5'b0};
    end else begin
      chan = wheel(hue);
    end
  end

  assign div_ctrl.start = accept;

  lpg_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (div_ctrl),
    .chan_i    (chan),
    .divisor_i (bright_q),
    .stat_o    (div_stat),
    .quot_o    (quot)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    load_out    = 1'b0;
    in_if.ready = 1'b0;
    out_valid_d = out_valid_q && !out_if.ready;
    case (state_q)
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (!out_valid_q || out_if.ready) begin
            load_out = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (!out_valid_q || out_if.ready) begin
          load_out = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  assign ticks_inc = frame_ticks_q + TICKS_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      mode_q        <= PATTERN_MODE_RST;
      bright_q      <= BRIGHTNESS_RST;
      frame_count_q <= '0;
      frame_ticks_q <= '0;
      slot_q        <= PATTERN_SLOT_RST;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_PATTERN_MODE: mode_q   <= cfg_data_i[2:0];
          REG_BRIGHTNESS:   bright_q <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (accept && in_if.frame_end) begin
        if (!release_mode) begin
          frame_count_q <= frame_count_q + 8'd1;
        end
        if (ticks_inc >= TICKS_W'(FRAMES_PER_PATTERN)) begin
          frame_ticks_q <= '0;
          slot_q        <= slot_q + 2'd1;
        end else begin
          frame_ticks_q <= ticks_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      drive_pend_q <= !release_mode;
    end
    if (load_out) begin
      out_rgb_q   <= quot;
      out_drive_q <= drive_pend_q;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.green        = out_rgb_q.green;
  assign out_if.red          = out_rgb_q.red;
  assign out_if.blue         = out_rgb_q.blue;
  assign out_if.drive_enable = out_drive_q;

  a_idle_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> !div_stat.busy)
    else $error("divider busy while idle");

  a_accept_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_DIV) && div_stat.busy)
    else $error("accepted item did not start divider");

  a_release_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.drive_enable) |->
      (out_if.green == '0) && (out_if.red == '0) && (out_if.blue == '0))
    else $error("released output carries colour");

  a_ticks_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_ticks_q < TICKS_W'(FRAMES_PER_PATTERN))
    else $error("frame tick counter out of range");

endmodule

@@ sim/tb_led_pattern_pixel_generator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_pattern_pixel_generator
// Self-checking bench for the LED pattern pixel generator. Requests are sent
// with random bursts and gaps, results are taken with random stalls, and each
// result is compared with a colour predicted from the mode, divisor, frame
// counter and pattern slot that the bench tracks on its own. The run visits
// every mode, the divisor extremes and several slots of cycle mode.
// ----------------------------------------------------------------------------
module tb_led_pattern_pixel_generator;
  import lpg_pkg::*;

  localparam logic [2:0] MODE_UNUSED    = 3'd7;
  localparam int unsigned SETTLE_CYCLES = 30;
  localparam int unsigned PHASES        = 24;
  localparam int unsigned PHASE_ITEMS   = 64;

  typedef struct packed {
    logic [6:0] led_index;
    logic [7:0] x_coord;
    logic [7:0] y_coord;
    logic [6:0] order_position;
    logic [7:0] pixel_byte;
    logic       frame_end;
  } led_req_t;

  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
    logic       drive_enable;
  } pixel_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lpg_in_if  req_ch ();
  lpg_out_if pix_ch ();

  led_pattern_pixel_generator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (req_ch),
    .out_if      (pix_ch),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // tracked block state
  logic [2:0]  cur_mode      = PATTERN_MODE_RST;
  logic [7:0]  brightness    = BRIGHTNESS_RST;
  logic [7:0]  frame_count   = '0;
  int unsigned frame_ticks   = 0;
  logic [1:0]  pattern_slot  = PATTERN_SLOT_RST;

  led_req_t pending_reqs[$];
  pixel_t   expected_pixels[$];
  int unsigned err_count  = 0;
  int unsigned pixel_num  = 0;
  logic        req_taken  = 1'b0;
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned rx_cycle   = 0;

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    req_ch.valid   = 1'b0;
    req_ch.led_index      = '0;
    req_ch.x_coord        = '0;
    req_ch.y_coord        = '0;
    req_ch.order_position = '0;
    req_ch.pixel_byte     = '0;
    req_ch.frame_end      = 1'b0;
    pix_ch.ready   = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic pixel_t predict_pixel(input led_req_t req);
    pixel_t      px;
    logic [2:0]  pat;
    int unsigned base, hue, p, q, g, r, b, d;
    px = '0;
    g = 0;
    r = 0;
    b = 0;
    base = 0;
    if (cur_mode < MODE_RELEASE) begin
      pat = (cur_mode == MODE_CYCLE) ? {1'b0, pattern_slot} : cur_mode;
      if (pat == MODE_FRAMEBUFFER) begin
        g = {req.pixel_byte[4:2], 5'b0};
        r = {req.pixel_byte[7:5], 5'b0};
        b = {req.pixel_byte[1:0], 5'b0};
      end else begin
        case (pat)
          MODE_PINWHEEL:   base = int'(req.led_index) * 2;
          MODE_HORIZONTAL: base = req.x_coord;
          MODE_SPIRAL:     base = ((LED_COUNT - 1 - int'(req.order_position)) % 256) * 2;
          default:         base = req.y_coord;
        endcase
        hue = (base + frame_count) % 256;
        p   = (256 - hue) % 256;
        if (p < WHEEL_SEG1) begin
          g = 0;
          r = CHAN_MAX - 3 * p;
          b = 3 * p;
        end else if (p < WHEEL_SEG2) begin
          q = p - WHEEL_SEG1;
          g = 3 * q;
          r = 0;
          b = CHAN_MAX - 3 * q;
        end else begin
          q = p - WHEEL_SEG2;
          g = CHAN_MAX - 3 * q;
          r = 3 * q;
          b = 0;
        end
      end
      d = (brightness == 0) ? 1 : brightness;
      px.green        = 8'(g / d);
      px.red          = 8'(r / d);
      px.blue         = 8'(b / d);
      px.drive_enable = 1'b1;
    end
    return px;
  endfunction

  function automatic void advance_frame(input led_req_t req);
    if (req.frame_end) begin
      if (cur_mode < MODE_RELEASE) frame_count++;
      frame_ticks++;
      if (frame_ticks >= FRAMES_PER_PATTERN) begin
        frame_ticks = 0;
        pattern_slot++;
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    $display("pixel %0d: %s got %0d, expected %0d", pixel_num, what, got, want);
  endtask

  // result check first, then prediction of the newly accepted item
  always @(posedge clk_i) begin
    pixel_t got, want;
    if (pix_ch.valid && pix_ch.ready) begin
      got = '{pix_ch.green, pix_ch.red, pix_ch.blue, pix_ch.drive_enable};
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected item, green", got.green, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (got.green != want.green) report_mismatch("green", got.green, want.green);
        if (got.red != want.red) report_mismatch("red", got.red, want.red);
        if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
        if (got.drive_enable !== want.drive_enable)
          report_mismatch("drive_enable", got.drive_enable, want.drive_enable);
      end
      pixel_num++;
    end
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      led_req_t req;
      req = '{req_ch.led_index, req_ch.x_coord, req_ch.y_coord,
              req_ch.order_position, req_ch.pixel_byte, req_ch.frame_end};
      expected_pixels.push_back(predict_pixel(req));
      advance_frame(req);
    end
    req_taken <= rst_ni && req_ch.valid && req_ch.ready;
  end

  // request driver: bursts with random gaps
  always @(negedge clk_i) begin
    led_req_t req;
    if (!rst_ni) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_taken) begin
      req_ch.valid <= 1'b1;
    end else if (gap_left != 0) begin
      gap_left--;
      req_ch.valid <= 1'b0;
    end else if (pending_reqs.size() != 0) begin
      req = pending_reqs.pop_front();
      req_ch.led_index      <= req.led_index;
      req_ch.x_coord        <= req.x_coord;
      req_ch.y_coord        <= req.y_coord;
      req_ch.order_position <= req.order_position;
      req_ch.pixel_byte     <= req.pixel_byte;
      req_ch.frame_end      <= req.frame_end;
      req_ch.valid          <= 1'b1;
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        case ($urandom_range(0, 3))
          0:       gap_left = $urandom_range(1, 3);
          1:       gap_left = $urandom_range(4, 40);
          default: gap_left = 0;
        endcase
      end
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  // result receiver: random stalls, with quiet windows of no stalling
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle[9]) begin
      stall_left = 0;
      pix_ch.ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left--;
      pix_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 40);
      pix_ch.ready <= 1'b0;
    end else begin
      pix_ch.ready <= 1'b1;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_ch.valid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input logic [2:0] mode, input logic [7:0] div);
    wait_drained();
    write_reg(REG_PATTERN_MODE, {5'($urandom_range(0, 31)), mode});
    write_reg(REG_BRIGHTNESS, div);
    cur_mode   = mode;
    brightness = div;
  endtask

  task automatic push_req(input logic [6:0] led, input logic [7:0] x, input logic [7:0] y,
                          input logic [6:0] order, input logic [7:0] pix, input logic fe);
    pending_reqs.push_back('{led, x, y, order, pix, fe});
  endtask

  initial begin
    logic [2:0] mode;
    logic [7:0] div;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings
    push_req(7'd0, 8'd0, 8'd0, 7'd0, 8'h00, 1'b0);
    push_req(7'd127, 8'd255, 8'd255, 7'd127, 8'hFF, 1'b1);
    // zero divisor passes channels undivided
    set_config(MODE_PINWHEEL, 8'd0);
    push_req(7'd0, 8'd17, 8'd33, 7'd5, 8'h5A, 1'b0);
    push_req(7'd127, 8'd90, 8'd200, 7'd64, 8'hA5, 1'b1);
    set_config(MODE_HORIZONTAL, 8'd1);
    push_req(7'd3, 8'd0, 8'd1, 7'd9, 8'h00, 1'b0);
    push_req(7'd4, 8'd255, 8'd2, 7'd10, 8'hFF, 1'b1);
    set_config(MODE_SPIRAL, 8'd255);
    push_req(7'd5, 8'd1, 8'd3, 7'd0, 8'h12, 1'b0);
    push_req(7'd6, 8'd2, 8'd4, 7'd127, 8'h34, 1'b1);
    set_config(MODE_VERTICAL, 8'd7);
    push_req(7'd7, 8'd3, 8'd0, 7'd1, 8'h56, 1'b0);
    push_req(7'd8, 8'd4, 8'd255, 7'd2, 8'h78, 1'b1);
    set_config(MODE_FRAMEBUFFER, 8'd0);
    push_req(7'd9, 8'd5, 8'd5, 7'd3, 8'hFF, 1'b0);
    push_req(7'd10, 8'd6, 8'd6, 7'd4, 8'hE0, 1'b0);
    push_req(7'd11, 8'd7, 8'd7, 7'd5, 8'h1C, 1'b0);
    push_req(7'd12, 8'd8, 8'd8, 7'd6, 8'h03, 1'b0);
    push_req(7'd13, 8'd9, 8'd9, 7'd7, 8'h00, 1'b1);
    set_config(MODE_FRAMEBUFFER, 8'd1);
    push_req(7'd14, 8'd10, 8'd10, 7'd8, 8'hFF, 1'b0);
    // release modes: line released, frame counter held, frame ticks still advance
    set_config(MODE_RELEASE, 8'd1);
    push_req(7'd15, 8'd11, 8'd11, 7'd9, 8'hFF, 1'b1);
    set_config(MODE_UNUSED, 8'd0);
    push_req(7'd16, 8'd12, 8'd12, 7'd10, 8'hFF, 1'b1);
    set_config(MODE_CYCLE, 8'd12);
    push_req(7'd17, 8'd13, 8'd13, 7'd11, 8'h99, 1'b0);

    // random phases; nearly every item ends a frame so cycle mode moves through its slots
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph % 2 == 1 || ph == PHASES - 1) mode = MODE_CYCLE;
      else mode = 3'($urandom_range(0, 7));
      case (ph % 4)
        0:       div = 8'd0;
        1:       div = 8'd1;
        2:       div = 8'd255;
        default: div = 8'($urandom_range(2, 254));
      endcase
      set_config(mode, div);
      for (int n = 0; n < PHASE_ITEMS; n++)
        push_req(7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                 8'($urandom_range(0, 255)), $urandom_range(0, 31) != 0);
    end

    while (pending_reqs.size() != 0 || req_ch.valid || expected_pixels.size() != 0)
      @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
